@@ rtl/fse_pkg.sv @@
package fse_pkg;

  localparam int COUNT_BITS = 16;
  localparam int PROB_BITS  = 17;
  localparam int FRAC_BITS  = 16;
  localparam int LOG_BITS   = 21;
  localparam int OUT_BITS   = 17;
  localparam int LANES      = 4;
  localparam logic [PROB_BITS-1:0] ONE_Q16 = 17'h10000;

  // Unsigned Q1.16 probability, saturated to 1.0.
  typedef logic [PROB_BITS-1:0] prob_t;

  // Index of the top set bit of a nonzero 16-bit value.
  function automatic logic [3:0] top_bit(input logic [15:0] v);
    logic [3:0] e;
    e = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        e = 4'(i);
      end
    end
    return e;
  endfunction

endpackage

@@ rtl/fse_div.sv @@
// Pipelined restoring divider: one quotient bit per stage.
// Computes floor(count * 2^16 / depth) for count < depth, saturated to 1.0 otherwise.
module fse_div import fse_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [COUNT_BITS-1:0] count,
  input  logic [COUNT_BITS-1:0] depth,
  output prob_t                 prob
);

  localparam int STEPS = FRAC_BITS;

  logic [COUNT_BITS:0]   rem_q [STEPS+1];
  logic [FRAC_BITS-1:0]  quo_q [STEPS+1];
  logic [COUNT_BITS-1:0] den_q [STEPS+1];
  logic                  sat_q [STEPS+1];

  // Stage zero: load remainder with count
  always_comb begin
    rem_q[0] = {1'b0, count};
    quo_q[0] = '0;
    den_q[0] = depth;
    sat_q[0] = (count >= depth);
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [COUNT_BITS+1:0] sh;
    logic [COUNT_BITS+1:0] diff;
    assign sh   = {rem_q[s], 1'b0};
    assign diff = sh - {2'b00, den_q[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        den_q[s+1] <= den_q[s];
        sat_q[s+1] <= sat_q[s];
        if (!diff[COUNT_BITS+1]) begin
          rem_q[s+1] <= diff[COUNT_BITS:0];
          quo_q[s+1] <= {quo_q[s][FRAC_BITS-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= sh[COUNT_BITS:0];
          quo_q[s+1] <= {quo_q[s][FRAC_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign prob = sat_q[STEPS] ? ONE_Q16 : {1'b0, quo_q[STEPS]};

endmodule

@@ rtl/fse_log.sv @@
// Pipelined term unit: p * (-log2 p) in Q.32 by 16 squaring stages.
// Terms with p == 0 or p == 1.0 give zero.
module fse_log import fse_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  prob_t       prob,
  output logic [37:0] term
);

  localparam int STEPS = FRAC_BITS;

  logic [31:0]          m_q    [STEPS+1];
  logic [FRAC_BITS-1:0] frac_q [STEPS+1];
  logic [3:0]           e_q    [STEPS+1];
  logic [15:0]          p_q    [STEPS+1];
  logic                 skip_q [STEPS+1];

  // Normalize mantissa into [2^31, 2^32)
  always_comb begin
    e_q[0]    = top_bit(prob[15:0]);
    m_q[0]    = {prob[15:0], 16'h0000} << (5'd15 - {1'b0, e_q[0]});
    frac_q[0] = '0;
    p_q[0]    = prob[15:0];
    skip_q[0] = prob[16] || (prob[15:0] == 16'h0000);
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] m2;
    assign sq = 64'(m_q[s]) * 64'(m_q[s]);
    assign m2 = sq[63:31];
    always_ff @(posedge clk) begin
      if (en) begin
        e_q[s+1]    <= e_q[s];
        p_q[s+1]    <= p_q[s];
        skip_q[s+1] <= skip_q[s];
        if (m2[32]) begin
          m_q[s+1]    <= m2[32:1];
          frac_q[s+1] <= {frac_q[s][FRAC_BITS-2:0], 1'b1};
        end else begin
          m_q[s+1]    <= m2[31:0];
          frac_q[s+1] <= {frac_q[s][FRAC_BITS-2:0], 1'b0};
        end
      end
    end
  end

  // Negated log and final product, registered
  logic [LOG_BITS-1:0] nlog;
  assign nlog = (LOG_BITS'(16) << 16) - {1'b0, e_q[STEPS], frac_q[STEPS]};

  always_ff @(posedge clk) begin
    if (en) begin
      term <= skip_q[STEPS] ? '0 : 38'(p_q[STEPS]) * 38'(nlog);
    end
  end

endmodule

@@ rtl/four_symbol_entropy.sv @@
// Base-4 Shannon entropy of four counts over a depth, one transaction per cycle.
// The pipeline accepts a new transaction every cycle it is not stalled; its stages
// are 16 divider stages, 16 squaring stages of the log unit, one product stage,
// one sum stage and the output register. Four divider and log lanes run in
// parallel. A stall on the output freezes the whole pipeline in place.
module four_symbol_entropy import fse_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COUNT_BITS-1:0] count_a,
  input  logic [COUNT_BITS-1:0] count_c,
  input  logic [COUNT_BITS-1:0] count_g,
  input  logic [COUNT_BITS-1:0] count_t,
  input  logic [COUNT_BITS-1:0] depth,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_BITS-1:0]   entropy_q16,
  output logic                  depth_zero
);

  localparam int LAT  = 2 * FRAC_BITS + 1;

  // The core advances only when the output register can take data
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic [COUNT_BITS-1:0] cnt [LANES];
  assign cnt[0] = count_a;
  assign cnt[1] = count_c;
  assign cnt[2] = count_g;
  assign cnt[3] = count_t;

  logic [37:0] term [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    prob_t p;
    fse_div u_div (.clk(clk), .en(en), .count(cnt[l]), .depth(depth), .prob(p));
    fse_log u_log (.clk(clk), .en(en), .prob(p), .term(term[l]));
  end

  // Valid and zero-depth flag alongside the lanes
  logic vld [LAT+1];
  logic dz  [LAT+1];
  assign vld[0] = in_valid;
  assign dz[0]  = (depth == '0);
  for (genvar s = 0; s < LAT; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dz[s+1] <= dz[s];
      end
    end
  end

  // Sum stage
  logic [39:0] sum;
  logic        sum_vld;
  logic        sum_dz;
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
    end else if (en) begin
      sum_vld <= vld[LAT];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sum    <= 40'(term[0]) + 40'(term[1]) + 40'(term[2]) + 40'(term[3]);
      sum_dz <= dz[LAT];
    end
  end

  // Scale, saturate, output register
  logic [22:0] h;
  assign h = sum[39:17];
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sum_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      depth_zero  <= sum_dz;
      entropy_q16 <= sum_dz ? '0 :
                     (h > 23'(ONE_Q16)) ? ONE_Q16 : h[OUT_BITS-1:0];
    end
  end

  // A stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(entropy_q16))
    else $error("stalled result changed");
  // Result never exceeds 1.0
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entropy_q16 <= ONE_Q16)
    else $error("entropy above 1.0");
  // Zero depth gives zero entropy
  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && depth_zero |-> entropy_q16 == '0)
    else $error("zero depth with nonzero entropy");
  // Input stalls only when output is held
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

endmodule

@@ test/four_symbol_entropy_tb.sv @@
`timescale 1ns / 1ps

module four_symbol_entropy_tb;
  import fse_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1850;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [COUNT_BITS-1:0] a;
    logic [COUNT_BITS-1:0] c;
    logic [COUNT_BITS-1:0] g;
    logic [COUNT_BITS-1:0] t;
    logic [COUNT_BITS-1:0] dp;
  } column_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] h;
    logic                dz;
  } entropy_t;

  // Directed row: a column and, where obvious, a typed-in expectation.
  typedef struct packed {
    column_t  col;
    logic     fixed;
    entropy_t want;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [COUNT_BITS-1:0] count_a = '0, count_c = '0, count_g = '0, count_t = '0;
  logic [COUNT_BITS-1:0] depth = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OUT_BITS-1:0] entropy_q16;
  logic depth_zero;

  entropy_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit no_idle = 1'b0;

  four_symbol_entropy u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // -log2(p/2^16) in Q.16 by repeated squaring of the mantissa
  function automatic logic [31:0] neg_log2(input logic [16:0] p);
    logic [3:0] e;
    logic [63:0] m;
    logic [15:0] frac;
    e = 4'd0;
    frac = '0;
    for (int i = 0; i < 16; i++) if (p[i]) e = 4'(i);
    m = 64'(p) << (31 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (32'd16 << 16) - {12'd0, e, frac};
  endfunction

  function automatic entropy_t predict_entropy(input column_t col);
    entropy_t r;
    logic [COUNT_BITS-1:0] cnt[4];
    logic [63:0] sum, h, q;
    logic [16:0] p;
    cnt = '{col.a, col.c, col.g, col.t};
    sum = '0;
    if (col.dp == 0) begin
      r.h = '0;
      r.dz = 1'b1;
      return r;
    end
    foreach (cnt[i]) begin
      if (cnt[i] >= col.dp) p = ONE_Q16;
      else begin
        q = (64'(cnt[i]) << 16) / 64'(col.dp);
        p = (q > 64'(ONE_Q16)) ? ONE_Q16 : q[16:0];
      end
      if (p != 0 && p < ONE_Q16) sum += 64'(p) * 64'(neg_log2(p));
    end
    h = sum >> 17;
    if (h > 64'(ONE_Q16)) h = 64'(ONE_Q16);
    r.h = h[OUT_BITS-1:0];
    r.dz = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR t=%0t %s", $time, what);
    errors++;
  endtask

  // Send one transaction, idling at random beforehand
  task automatic send_column(input column_t col, input entropy_t want);
    while (!no_idle && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {count_a, count_c, count_g, count_t, depth} <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(want);
  endtask

  function automatic column_t random_column();
    column_t col;
    logic [COUNT_BITS-1:0] d;
    int mode;
    mode = $urandom_range(9);
    col = column_t'({$urandom, $urandom, $urandom});
    if (mode < 6) begin
      // well-formed column: counts sum to the depth, half of them with small depths
      d = (mode < 3) ? COUNT_BITS'($urandom_range(1, 300)) : COUNT_BITS'($urandom);
      if (d == 0) d = 1;
      col.dp = d;
      col.a = COUNT_BITS'($urandom_range(0, d));
      col.c = COUNT_BITS'($urandom_range(0, d - col.a));
      col.g = COUNT_BITS'($urandom_range(0, d - col.a - col.c));
      col.t = d - col.a - col.c - col.g;
    end else if (mode == 6) begin
      col.dp = '0;
    end
    return col;
  endfunction

  // Receiver: random stall, one long hold-off, no-idle stretch
  always @(posedge clk) begin
    if (rst || no_idle) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < 26);
  end

  // Compare each accepted result against the oldest expectation
  always @(posedge clk) begin
    entropy_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) report_mismatch("result with nothing expected");
      else begin
        want = expected_q.pop_front();
        if (entropy_q16 !== want.h)
          report_mismatch($sformatf("entropy_q16 %0d want %0d", entropy_q16, want.h));
        if (depth_zero !== want.dz)
          report_mismatch($sformatf("depth_zero %0b want %0b", depth_zero, want.dz));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Long hold-off on the output, counted in cycles
  initial begin
    wait (!rst);
    repeat (400) @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    vector_t rows[$];
    column_t col;
    entropy_t want;
    rows = '{
      '{column_t'({16'd5, 16'd5, 16'd5, 16'd5, 16'd0}), 1'b1, entropy_t'({17'd0, 1'b1})},
      '{column_t'({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0}), 1'b1,
        entropy_t'({17'd0, 1'b1})},
      '{column_t'({16'd10, 16'd0, 16'd0, 16'd0, 16'd10}), 1'b1, entropy_t'({17'd0, 1'b0})},
      '{column_t'({16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF}), 1'b1, entropy_t'({17'd0, 1'b0})},
      '{column_t'({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1}), 1'b1,
        entropy_t'({17'd0, 1'b0})},
      '{column_t'({16'd1, 16'd1, 16'd1, 16'd1, 16'd4}), 1'b0, '0},
      '{column_t'({16'd16384, 16'd16384, 16'd16384, 16'd16383, 16'hFFFF}), 1'b0, '0},
      '{column_t'({16'd1, 16'd0, 16'd0, 16'd0, 16'hFFFF}), 1'b0, '0},
      '{column_t'({16'd1, 16'd1, 16'd0, 16'd0, 16'd2}), 1'b0, '0},
      '{column_t'({16'd3, 16'd3, 16'd3, 16'd3, 16'd4}), 1'b0, '0},
      '{column_t'({16'hFFFE, 16'd1, 16'd0, 16'd0, 16'hFFFF}), 1'b0, '0},
      '{column_t'({16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF}), 1'b0, '0},
      '{column_t'({16'd1, 16'd2, 16'd3, 16'd4, 16'd10}), 1'b0, '0},
      '{column_t'({16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0, 16'hFFFE}), 1'b0, '0}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      want = rows[i].fixed ? rows[i].want : predict_entropy(rows[i].col);
      send_column(rows[i].col, want);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 1200 && n < 1400);
      col = random_column();
      send_column(col, predict_entropy(col));
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
